[src/cf3p_pkg.sv]
package cf3p_pkg;

   localparam int FIELD_W  = 16;
   localparam int OUT_W    = 40;
   localparam int OFF_W    = 42;            // signed centre offset, |off| < 2^41
   localparam int AX_W     = OFF_W - 1;     // offset magnitude
   localparam int QUO_W    = 43;            // quotient bits resolved by the divider
   localparam int DIV_LAT  = QUO_W + 2;     // setup + one bit per stage + rounding
   localparam int HALF_LO  = 21;            // split point for squaring the offsets
   localparam int HI_W     = AX_W - HALF_LO;
   localparam int SQ_W     = 84;            // ox^2 + oy^2 < 2^83
   localparam int ROOT_W   = 42;            // floor sqrt of a SQ_W value
   localparam int TRIAL_W  = 86;
   localparam int SQRT_LAT = ROOT_W + 2;    // capture + one bit per stage + rounding
   localparam int CS_W     = OFF_W + 1;     // unsaturated centre

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_DEGEN = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   localparam logic signed [OUT_W-1:0] CEN_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] CEN_MIN = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic [OUT_W-1:0]        RAD_MAX = {OUT_W{1'b1}};

   typedef struct packed {
      logic signed [FIELD_W-1:0] first_x;
      logic signed [FIELD_W-1:0] first_y;
      logic signed [FIELD_W-1:0] second_x;
      logic signed [FIELD_W-1:0] second_y;
      logic signed [FIELD_W-1:0] third_x;
      logic signed [FIELD_W-1:0] third_y;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] center_x;
      logic signed [OUT_W-1:0] center_y;
      logic [OUT_W-1:0]        radius;
      logic [1:0]              status;
   } rsp_type;

   typedef struct packed {
      logic                    big;
      logic signed [OFF_W-1:0] off;
   } div_res_type;

endpackage

[src/cf3p_front.sv]
module cf3p_front import cf3p_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                            clock,
   input  logic                            en,
   input  req_type                         req,
   output logic signed [COORD_BITS-1:0]    x1,
   output logic signed [COORD_BITS-1:0]    y1,
   output logic signed [3*COORD_BITS+3:0]  nx,
   output logic signed [3*COORD_BITS+3:0]  ny,
   output logic signed [2*COORD_BITS+3:0]  det,
   output logic                            degen
);

   localparam int C   = COORD_BITS;
   localparam int DFW = C + 1;
   localparam int PW  = 2*C + 2;
   localparam int DW  = 2*C + 4;
   localparam int SW  = 2*C + 2;
   localparam int LW  = C + 1;
   localparam int PPW = DFW + LW + 1;
   localparam int NXW = 3*C + 4;

   logic signed [FIELD_W-1:0] raw [6];
   logic signed [C-1:0]       crd [6];

   assign raw[0] = req.first_x;
   assign raw[1] = req.first_y;
   assign raw[2] = req.second_x;
   assign raw[3] = req.second_y;
   assign raw[4] = req.third_x;
   assign raw[5] = req.third_y;

   for (genvar i = 0; i < 6; i++) begin : g_crd
      if (C <= FIELD_W) begin : g_low
         assign crd[i] = raw[i][C-1:0];
      end else begin : g_ext
         assign crd[i] = C'(raw[i]);
      end
   end

   // stage 1: offsets from the first point
   logic signed [C-1:0]   x1_s1_ff, y1_s1_ff;
   logic signed [DFW-1:0] u_s1_ff, v_s1_ff, p_s1_ff, q_s1_ff;
   // stage 2: products
   logic signed [C-1:0]   x1_s2_ff, y1_s2_ff;
   logic signed [DFW-1:0] u_s2_ff, v_s2_ff, p_s2_ff, q_s2_ff;
   logic signed [PW-1:0]  uq_ff, vp_ff, uu_ff, vv_ff, pp_ff, qq_ff;
   // stage 3: determinant and squared lengths
   logic signed [C-1:0]   x1_s3_ff, y1_s3_ff;
   logic signed [DFW-1:0] u_s3_ff, v_s3_ff, p_s3_ff, q_s3_ff;
   logic signed [DW-1:0]  det_s3_ff;
   logic [SW-1:0]         sa_ff, sb_ff;
   // stage 4: partial products, squared lengths split at LW
   logic signed [C-1:0]   x1_s4_ff, y1_s4_ff;
   logic signed [DW-1:0]  det_s4_ff;
   logic signed [PPW-1:0] qal_ff, qah_ff, vbl_ff, vbh_ff, ubl_ff, ubh_ff, pal_ff, pah_ff;
   // stage 5: numerators
   logic signed [C-1:0]   x1_ff, y1_ff;
   logic signed [NXW-1:0] nx_ff, ny_ff;
   logic signed [DW-1:0]  det_ff;
   logic                  degen_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x1_s1_ff <= crd[0];
         y1_s1_ff <= crd[1];
         u_s1_ff  <= DFW'(crd[2]) - DFW'(crd[0]);
         v_s1_ff  <= DFW'(crd[3]) - DFW'(crd[1]);
         p_s1_ff  <= DFW'(crd[4]) - DFW'(crd[0]);
         q_s1_ff  <= DFW'(crd[5]) - DFW'(crd[1]);

         x1_s2_ff <= x1_s1_ff;
         y1_s2_ff <= y1_s1_ff;
         u_s2_ff  <= u_s1_ff;
         v_s2_ff  <= v_s1_ff;
         p_s2_ff  <= p_s1_ff;
         q_s2_ff  <= q_s1_ff;
         uq_ff    <= u_s1_ff * q_s1_ff;
         vp_ff    <= v_s1_ff * p_s1_ff;
         uu_ff    <= u_s1_ff * u_s1_ff;
         vv_ff    <= v_s1_ff * v_s1_ff;
         pp_ff    <= p_s1_ff * p_s1_ff;
         qq_ff    <= q_s1_ff * q_s1_ff;

         x1_s3_ff  <= x1_s2_ff;
         y1_s3_ff  <= y1_s2_ff;
         u_s3_ff   <= u_s2_ff;
         v_s3_ff   <= v_s2_ff;
         p_s3_ff   <= p_s2_ff;
         q_s3_ff   <= q_s2_ff;
         det_s3_ff <= (DW'(uq_ff) - DW'(vp_ff)) <<< 1;
         sa_ff     <= unsigned'(uu_ff) + unsigned'(vv_ff);
         sb_ff     <= unsigned'(pp_ff) + unsigned'(qq_ff);

         x1_s4_ff  <= x1_s3_ff;
         y1_s4_ff  <= y1_s3_ff;
         det_s4_ff <= det_s3_ff;
         qal_ff    <= q_s3_ff * $signed({1'b0, sa_ff[LW-1:0]});
         qah_ff    <= q_s3_ff * $signed({1'b0, sa_ff[SW-1:LW]});
         vbl_ff    <= v_s3_ff * $signed({1'b0, sb_ff[LW-1:0]});
         vbh_ff    <= v_s3_ff * $signed({1'b0, sb_ff[SW-1:LW]});
         ubl_ff    <= u_s3_ff * $signed({1'b0, sb_ff[LW-1:0]});
         ubh_ff    <= u_s3_ff * $signed({1'b0, sb_ff[SW-1:LW]});
         pal_ff    <= p_s3_ff * $signed({1'b0, sa_ff[LW-1:0]});
         pah_ff    <= p_s3_ff * $signed({1'b0, sa_ff[SW-1:LW]});

         x1_ff    <= x1_s4_ff;
         y1_ff    <= y1_s4_ff;
         det_ff   <= det_s4_ff;
         degen_ff <= (det_s4_ff == '0);
         nx_ff    <= ((NXW'(qah_ff) <<< LW) + NXW'(qal_ff))
                   - ((NXW'(vbh_ff) <<< LW) + NXW'(vbl_ff));
         ny_ff    <= ((NXW'(ubh_ff) <<< LW) + NXW'(ubl_ff))
                   - ((NXW'(pah_ff) <<< LW) + NXW'(pal_ff));
      end
   end

   assign x1    = x1_ff;
   assign y1    = y1_ff;
   assign nx    = nx_ff;
   assign ny    = ny_ff;
   assign det   = det_ff;
   assign degen = degen_ff;

endmodule

[src/cf3p_div.sv]
module cf3p_div import cf3p_pkg::*; #(
   parameter int NUM_W     = 52,
   parameter int DEN_W     = 36,
   parameter int FRAC_BITS = 4
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [DEN_W-1:0] den,
   output div_res_type             res
);

   localparam int NW = NUM_W + FRAC_BITS;
   localparam int W  = (NW > DEN_W + QUO_W) ? NW : DEN_W + QUO_W;

   logic [NUM_W-1:0] num_mag;
   logic [DEN_W-1:0] den_mag;

   logic [W-1:0]     rem_ff [QUO_W+1];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];
   logic [DEN_W-1:0] dm_ff  [QUO_W+1];
   logic             neg_ff [QUO_W+1];
   div_res_type      res_ff;

   assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= W'(num_mag) << FRAC_BITS;
         quo_ff[0] <= '0;
         dm_ff[0]  <= den_mag;
         neg_ff[0] <= num[NUM_W-1] ^ den[DEN_W-1];
      end
   end

   // restoring division, one quotient bit per stage, MSB first
   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      localparam int B = QUO_W - 1 - i;
      logic [W-1:0] trial;
      logic         ge;
      logic [W-1:0] rem_in;

      assign trial  = W'(dm_ff[i]) << B;
      assign ge     = rem_ff[i] >= trial;
      assign rem_in = ge ? rem_ff[i] - trial : rem_ff[i];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= rem_in;
            quo_ff[i+1] <= {quo_ff[i][QUO_W-2:0], ge};
            dm_ff[i+1]  <= dm_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   // round half away from zero on the magnitude
   logic             rnd_up;
   logic [QUO_W:0]   quo_rnd;
   logic [AX_W-1:0]  quo_mag;
   div_res_type      res_in;

   always_comb begin
      rnd_up  = {rem_ff[QUO_W], 1'b0} >= (W+1)'(dm_ff[QUO_W]);
      quo_rnd = (QUO_W+1)'(quo_ff[QUO_W]) + (QUO_W+1)'(rnd_up);
      quo_mag = quo_rnd[AX_W-1:0];
      res_in.big = |quo_rnd[QUO_W:AX_W];
      res_in.off = neg_ff[QUO_W] ? -OFF_W'(quo_mag) : OFF_W'(quo_mag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

[src/cf3p_sqrt.sv]
module cf3p_sqrt import cf3p_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [SQ_W-1:0]   sq,
   output logic [ROOT_W:0]   root
);

   logic [SQ_W-1:0]   rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0] root_ff [ROOT_W+1];
   logic [ROOT_W:0]   out_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= sq;
         root_ff[0] <= '0;
      end
   end

   // digit-by-digit square root, one root bit per stage
   for (genvar i = 0; i < ROOT_W; i++) begin : g_step
      localparam int B = ROOT_W - 1 - i;
      logic [TRIAL_W-1:0] trial;
      logic               ge;
      logic [SQ_W-1:0]    rem_in;

      // root so far has no bits at or below B, so OR acts as add
      assign trial  = (TRIAL_W'(root_ff[i]) << (B + 1)) | (TRIAL_W'(1) << (2*B));
      assign ge     = TRIAL_W'(rem_ff[i]) >= trial;
      assign rem_in = ge ? SQ_W'(TRIAL_W'(rem_ff[i]) - trial) : rem_ff[i];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1]  <= rem_in;
            root_ff[i+1] <= root_ff[i] | (ROOT_W'(ge) << B);
         end
      end
   end

   // r^2 + r < s  <=>  s - r^2 > r
   logic rnd_up;
   assign rnd_up = rem_ff[ROOT_W] > SQ_W'(root_ff[ROOT_W]);

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= (ROOT_W+1)'(root_ff[ROOT_W]) + (ROOT_W+1)'(rnd_up);
      end
   end

   assign root = out_ff;

endmodule

[src/circle_from_three_points_unit.sv]
// Circumcircle of three points: centre and radius in fixed point.
// Pipeline: 5 front stages, 45 divider stages, 2 placement/squaring stages,
// 44 square-root stages and an output register.
// Throughput: one request per cycle unless stalled; bit-per-stage divider and root.
// Reset clears all valid bits, the output valid included; data registers are not reset.
module circle_from_three_points_unit import cf3p_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int C    = COORD_BITS;
   localparam int NXW  = 3*C + 4;
   localparam int DW   = 2*C + 4;
   localparam int PIPE = 5 + DIV_LAT + 2 + SQRT_LAT;

   typedef struct packed {
      logic signed [C-1:0] x1;
      logic signed [C-1:0] y1;
      logic                degen;
   } side_a_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] cx;
      logic signed [OUT_W-1:0] cy;
      logic                    sat;
      logic                    big;
      logic                    degen;
   } side_b_type;

   logic en;
   logic vld_ff [PIPE];
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic rsp_load;

   // stall only when a result reaches the end and the output is still held
   assign rsp_load  = !(rsp_valid_ff && !rsp_ready);
   assign en        = !(vld_ff[PIPE-1] && rsp_valid_ff && !rsp_ready);
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < PIPE; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // front: offsets, determinant, Cramer numerators
   logic signed [C-1:0]   f_x1, f_y1;
   logic signed [NXW-1:0] f_nx, f_ny;
   logic signed [DW-1:0]  f_det;
   logic                  f_degen;

   cf3p_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock (clock),
      .en    (en),
      .req   (req),
      .x1    (f_x1),
      .y1    (f_y1),
      .nx    (f_nx),
      .ny    (f_ny),
      .det   (f_det),
      .degen (f_degen)
   );

   div_res_type res_x, res_y;

   cf3p_div #(.NUM_W(NXW), .DEN_W(DW), .FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock),
      .en    (en),
      .num   (f_nx),
      .den   (f_det),
      .res   (res_x)
   );

   cf3p_div #(.NUM_W(NXW), .DEN_W(DW), .FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock),
      .en    (en),
      .num   (f_ny),
      .den   (f_det),
      .res   (res_y)
   );

   side_a_type sa_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff[0] <= '{x1: f_x1, y1: f_y1, degen: f_degen};
         for (int i = 1; i < DIV_LAT; i++) begin
            sa_ff[i] <= sa_ff[i-1];
         end
      end
   end

   // placement: centre = first point + offset, saturated
   logic signed [CS_W-1:0] sum_x, sum_y;
   side_b_type             pl_in;
   logic [AX_W-1:0]        ax_in, ay_in;

   always_comb begin
      sum_x = (CS_W'(sa_ff[DIV_LAT-1].x1) <<< FRAC_BITS) + CS_W'(res_x.off);
      sum_y = (CS_W'(sa_ff[DIV_LAT-1].y1) <<< FRAC_BITS) + CS_W'(res_y.off);
      pl_in.big   = res_x.big || res_y.big;
      pl_in.degen = sa_ff[DIV_LAT-1].degen;
      pl_in.sat   = 1'b0;
      // an oversized offset pins the centre high
      if (res_x.big) begin
         pl_in.cx  = CEN_MAX;
         pl_in.sat = 1'b1;
      end else if (sum_x > CS_W'(CEN_MAX)) begin
         pl_in.cx  = CEN_MAX;
         pl_in.sat = 1'b1;
      end else if (sum_x < CS_W'(CEN_MIN)) begin
         pl_in.cx  = CEN_MIN;
         pl_in.sat = 1'b1;
      end else begin
         pl_in.cx  = OUT_W'(sum_x);
      end
      if (res_y.big) begin
         pl_in.cy  = CEN_MAX;
         pl_in.sat = 1'b1;
      end else if (sum_y > CS_W'(CEN_MAX)) begin
         pl_in.cy  = CEN_MAX;
         pl_in.sat = 1'b1;
      end else if (sum_y < CS_W'(CEN_MIN)) begin
         pl_in.cy  = CEN_MIN;
         pl_in.sat = 1'b1;
      end else begin
         pl_in.cy  = OUT_W'(sum_y);
      end
      ax_in = res_x.off[OFF_W-1] ? AX_W'(-res_x.off) : AX_W'(res_x.off);
      ay_in = res_y.off[OFF_W-1] ? AX_W'(-res_y.off) : AX_W'(res_y.off);
   end

   side_b_type      pl_ff;
   logic [AX_W-1:0] ax_ff, ay_ff;

   // squaring split in halves so no multiplier exceeds about 21 bits
   logic [2*HI_W-1:0]         hhx_ff, hhy_ff;
   logic [HI_W+HALF_LO-1:0]   hlx_ff, hly_ff;
   logic [2*HALF_LO-1:0]      llx_ff, lly_ff;
   side_b_type                sq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff  <= pl_in;
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;

         sq_ff  <= pl_ff;
         hhx_ff <= ax_ff[AX_W-1:HALF_LO] * ax_ff[AX_W-1:HALF_LO];
         hlx_ff <= ax_ff[AX_W-1:HALF_LO] * ax_ff[HALF_LO-1:0];
         llx_ff <= ax_ff[HALF_LO-1:0] * ax_ff[HALF_LO-1:0];
         hhy_ff <= ay_ff[AX_W-1:HALF_LO] * ay_ff[AX_W-1:HALF_LO];
         hly_ff <= ay_ff[AX_W-1:HALF_LO] * ay_ff[HALF_LO-1:0];
         lly_ff <= ay_ff[HALF_LO-1:0] * ay_ff[HALF_LO-1:0];
      end
   end

   logic [SQ_W-1:0] dist_sq;

   assign dist_sq = (SQ_W'(hhx_ff) << (2*HALF_LO)) + (SQ_W'(hlx_ff) << (HALF_LO + 1))
                  + SQ_W'(llx_ff)
                  + (SQ_W'(hhy_ff) << (2*HALF_LO)) + (SQ_W'(hly_ff) << (HALF_LO + 1))
                  + SQ_W'(lly_ff);

   logic [ROOT_W:0] root;

   cf3p_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .sq    (dist_sq),
      .root  (root)
   );

   side_b_type sb_ff [SQRT_LAT];

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0] <= sq_ff;
         for (int i = 1; i < SQRT_LAT; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
      end
   end

   // final assembly
   side_b_type fin;
   rsp_type    rsp_in;
   logic       rad_over;

   always_comb begin
      fin      = sb_ff[SQRT_LAT-1];
      rad_over = |root[ROOT_W:OUT_W];
      if (fin.degen) begin
         rsp_in.center_x = '0;
         rsp_in.center_y = '0;
         rsp_in.radius   = '0;
         rsp_in.status   = STATUS_DEGEN;
      end else if (fin.big) begin
         rsp_in.center_x = fin.cx;
         rsp_in.center_y = fin.cy;
         rsp_in.radius   = RAD_MAX;
         rsp_in.status   = STATUS_SAT;
      end else begin
         rsp_in.center_x = fin.cx;
         rsp_in.center_y = fin.cy;
         rsp_in.radius   = rad_over ? RAD_MAX : root[OUT_W-1:0];
         rsp_in.status   = (fin.sat || rad_over) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= vld_ff[PIPE-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[src/cf3p_check.sv]
module cf3p_check import cf3p_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("result changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.status == STATUS_OK || rsp.status == STATUS_DEGEN
                    || rsp.status == STATUS_SAT)
      else $error("undefined status");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == STATUS_DEGEN |->
         rsp.center_x == '0 && rsp.center_y == '0 && rsp.radius == '0)
      else $error("degenerate result not zeroed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind circle_from_three_points_unit cf3p_check u_check (.*);

[verif/testbench.sv]
module testbench;
   import cf3p_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 4;
   localparam int LATENCY    = 97;
   localparam int WATCHDOG   = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp;

   rsp_type circle_queue[$];
   int      error_count;
   int      idle_cycles;

   circle_from_three_points_unit #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req(req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp(rsp)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [63:0] coord_value(logic [FIELD_W-1:0] raw);
      logic [63:0] v;
      v = 64'(raw) & ((64'd1 << COORD_BITS) - 64'd1);
      if (v[COORD_BITS-1]) return $signed(v) - $signed(64'd1 << COORD_BITS);
      return $signed(v);
   endfunction

   // round(num * 2^FRAC / den), ties away from zero; big set when |q| >= 2^41
   function automatic logic signed [63:0] rounded_offset(logic signed [127:0] num,
         logic signed [63:0] den, output logic big);
      logic [127:0] mag;
      logic [127:0] dm;
      logic [127:0] quot;
      logic [127:0] rem;
      logic         neg;
      mag  = num[127] ? 128'(-num) : 128'(num);
      dm   = den < 0 ? 128'(-den) : 128'(den);
      mag  = mag << FRAC_BITS;
      quot = mag / dm;
      rem  = mag % dm;
      if (rem >= dm - rem) quot = quot + 1;
      big = quot >= (128'd1 << 41);
      if (big) return 0;
      neg = num[127] != (den < 0);
      return neg ? -$signed(quot[63:0]) : $signed(quot[63:0]);
   endfunction

   function automatic logic signed [63:0] placed_center(logic signed [63:0] base,
         logic signed [63:0] off, logic big, inout logic [1:0] status);
      logic signed [63:0] c;
      if (big) begin
         status = STATUS_SAT;
         return off < 0 ? 64'(CEN_MIN) : 64'(CEN_MAX);
      end
      c = base * (64'sd1 <<< FRAC_BITS) + off;
      if (c > 64'(CEN_MAX)) begin
         status = STATUS_SAT;
         return 64'(CEN_MAX);
      end
      if (c < 64'(CEN_MIN)) begin
         status = STATUS_SAT;
         return 64'(CEN_MIN);
      end
      return c;
   endfunction

   function automatic rsp_type circumcircle(req_type r);
      rsp_type            res;
      logic signed [63:0] x1, y1, u, v, p, q, det, ox, oy, cx, cy;
      logic signed [127:0] sa, sb, nx, ny;
      logic [127:0]       sq, ax, ay, root, trial;
      logic               bigx, bigy;
      logic [1:0]         status;
      x1 = coord_value(r.first_x);
      y1 = coord_value(r.first_y);
      u = coord_value(r.second_x) - x1;
      v = coord_value(r.second_y) - y1;
      p = coord_value(r.third_x) - x1;
      q = coord_value(r.third_y) - y1;
      det = 2 * (u * q - v * p);
      res = '0;
      if (det == 0) begin
         res.status = STATUS_DEGEN;
         return res;
      end
      status = STATUS_OK;
      sa = 128'(u * u) + 128'(v * v);
      sb = 128'(p * p) + 128'(q * q);
      nx = 128'(q) * sa - 128'(v) * sb;
      ny = 128'(u) * sb - 128'(p) * sa;
      ox = rounded_offset(nx, det, bigx);
      oy = rounded_offset(ny, det, bigy);
      cx = placed_center(x1, ox, bigx, status);
      cy = placed_center(y1, oy, bigy, status);
      if (bigx || bigy) begin
         res.radius = RAD_MAX;
         status = STATUS_SAT;
      end else begin
         ax = ox < 0 ? 128'(-ox) : 128'(ox);
         ay = oy < 0 ? 128'(-oy) : 128'(oy);
         sq = ax * ax + ay * ay;
         root = 0;
         for (int b = 42; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= sq) root = trial;
         end
         if (root * root + root < sq) root = root + 1;
         if (root > 128'(RAD_MAX)) begin
            root = 128'(RAD_MAX);
            status = STATUS_SAT;
         end
         res.radius = root[OUT_W-1:0];
      end
      res.center_x = cx[OUT_W-1:0];
      res.center_y = cy[OUT_W-1:0];
      res.status = status;
      return res;
   endfunction

   // valid stays high across back-to-back requests; dropped only for a gap
   task automatic send_points(req_type r);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= r;
      circle_queue.push_back(circumcircle(r));
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [FIELD_W-1:0] random_coord(int spread);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 16'($urandom);
      if (pick == 1) return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      return 16'($signed($urandom_range(0, 2 * spread)) - spread);
   endfunction

   function automatic req_type random_points(int spread);
      req_type r;
      r.first_x  = random_coord(spread);
      r.first_y  = random_coord(spread);
      r.second_x = random_coord(spread);
      r.second_y = random_coord(spread);
      r.third_x  = random_coord(spread);
      r.third_y  = random_coord(spread);
      return r;
   endfunction

   task automatic test_extremes();
      send_points('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
      send_points('{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
      send_points('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh8000});
      send_points('{16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0001});
      send_points('{16'shffff, 16'shffff, 16'sh0001, 16'sh0001, 16'shffff, 16'sh0001});
      send_points('{16'sh0000, 16'sh0000, 16'sh0003, 16'sh0000, 16'sh0001, 16'sh0002});
   endtask

   task automatic test_degenerate();
      send_points('{16'sh0005, 16'sh0005, 16'sh0005, 16'sh0005, 16'sh0005, 16'sh0005});
      send_points('{16'sh0000, 16'sh0000, 16'sh0002, 16'sh0002, 16'sh0004, 16'sh0004});
      send_points('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh0000});
      send_points('{16'sh0001, 16'sh0002, 16'sh0001, 16'sh0002, 16'sh0007, 16'shfff0});
   endtask

   task automatic test_saturation();
      // mostly nearly collinear; the far-apart ones give huge offset and radius
      send_points('{16'sh8000, 16'sh0000, 16'sh7fff, 16'sh0001, 16'sh7ffe, 16'sh0000});
      send_points('{16'sh8000, 16'sh0000, 16'sh7fff, 16'shffff, 16'sh7ffe, 16'sh0000});
      send_points('{16'sh0000, 16'sh8000, 16'sh0001, 16'sh7fff, 16'sh0000, 16'sh7ffe});
      send_points('{16'sh7fff, 16'sh7fff, 16'sh7ffe, 16'sh7ffe, 16'sh8000, 16'sh7ffe});
      send_points('{16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7ffe, 16'sh8001, 16'sh8000});
      send_points('{16'sh0000, 16'sh0000, 16'sh0100, 16'sh0001, 16'sh0200, 16'sh0000});
   endtask

   task automatic test_random();
      req_type r;
      int      spread;
      for (int n = 0; n < 1500; n++) begin
         case ($urandom_range(0, 3))
            0: spread = 20;
            1: spread = 1000;
            default: spread = 32767;
         endcase
         r = random_points(spread);
         // nudge some toward nearly collinear to reach saturation
         if ($urandom_range(0, 7) == 0) begin
            r.third_x = 16'(r.second_x + (r.second_x - r.first_x)
                           + 16'($urandom_range(0, 2)) - 1);
            r.third_y = r.second_y + (r.second_y - r.first_y);
         end
         send_points(r);
      end
   endtask

   initial begin
      int   gap;
      logic mismatch;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (circle_queue.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp);
               error_count++;
            end else begin
               rsp_type exp;
               exp = circle_queue.pop_front();
               mismatch = exp.center_x !== rsp.center_x || exp.center_y !== rsp.center_y
                  || exp.radius !== rsp.radius || exp.status !== rsp.status;
               if (mismatch) begin
                  $display("%0t: expected cx %h cy %h r %h st %0d, actual cx %h cy %h r %h st %0d",
                     $time, exp.center_x, exp.center_y, exp.radius, exp.status,
                     rsp.center_x, rsp.center_y, rsp.radius, rsp.status);
                  error_count++;
               end
            end
         end
         gap = gap_length();
         rsp_ready <= (gap == 0) || ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   initial begin
      error_count = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_degenerate();
      test_saturation();
      test_random();
      req_valid <= 1'b0;
      while (circle_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end
endmodule
